// ===== sv/wav_hp_pkg.sv =====
// shared types, codes and constants of the wav header parser
package wav_hp_pkg;

  localparam int unsigned IN_FIFO_DEPTH  = 4;
  localparam int unsigned OUT_FIFO_DEPTH = 2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NO_RIFF   = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE   = 3'd1;
  localparam logic [2:0] ERR_NO_FMT    = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
  localparam logic [2:0] ERR_NO_DATA   = 3'd4;
  localparam logic [2:0] ERR_BAD_DEPTH = 3'd5;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] PCM_BODY_BYTES = 32'd16;
  localparam logic [15:0] DEPTH_8        = 16'd8;
  localparam logic [15:0] DEPTH_16       = 16'd16;
  localparam logic [15:0] PCM_FORMAT     = 16'd1;
  localparam logic [15:0] MONO_CHANNELS  = 16'd1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  format_code;
    logic [31:0] rate_hz;
    logic [31:0] data_length;
    logic [2:0]  error_code;
    logic        last_data;
  } out_item_t;

endpackage

// ===== sv/wav_hp_fifo.sv =====
// small register queue with show-ahead read
module wav_hp_fifo import wav_hp_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = IN_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/wav_hp_parser.sv =====
// byte-wise riff/wave header state machine and data pass-through
module wav_hp_parser import wav_hp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_valid,
  input  in_item_t  byte_item,
  output logic      byte_take,
  input  logic      res_space,
  output logic      res_push,
  output out_item_t res_item
);

  localparam logic [3:0] PH_RIFF    = 4'd0;
  localparam logic [3:0] PH_RSIZE   = 4'd1;
  localparam logic [3:0] PH_WAVE    = 4'd2;
  localparam logic [3:0] PH_FMT     = 4'd3;
  localparam logic [3:0] PH_FSIZE   = 4'd4;
  localparam logic [3:0] PH_FBODY   = 4'd5;
  localparam logic [3:0] PH_FSKIP   = 4'd6;
  localparam logic [3:0] PH_CTAG    = 4'd7;
  localparam logic [3:0] PH_CSIZE   = 4'd8;
  localparam logic [3:0] PH_CSKIP   = 4'd9;
  localparam logic [3:0] PH_DATA    = 4'd10;
  localparam logic [3:0] PH_DISCARD = 4'd11;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] fmt_size_r, fmt_size_nxt;
  logic [15:0] audio_fmt_r, audio_fmt_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] remain_r, remain_nxt;

  logic [7:0]  b;
  logic        eof;
  logic [1:0]  sel;
  logic [31:0] part;
  logic [31:0] tag_in;
  logic        tag_done;
  logic [31:0] remain_or;
  logic [31:0] remain_dec;
  logic        before_data;
  logic        err;
  out_item_t   res;
  logic        res_valid;

  assign byte_take = byte_valid && res_space;
  assign res_push  = byte_take && res_valid;
  assign res_item  = res;

  assign b          = byte_item.file_byte;
  assign eof        = byte_item.end_of_file;
  assign tag_in     = {tag_r[23:0], b};
  assign tag_done   = (cnt_r >= 4'd3);
  assign remain_dec = remain_r - 32'd1;

  // byte lane inside the current little-endian field
  always_comb begin
    if (phase_r == PH_FBODY && (cnt_r < 4'd4 || cnt_r >= 4'd12)) begin
      sel = {1'b0, cnt_r[0]};
    end else begin
      sel = cnt_r[1:0];
    end
  end

  assign part      = {24'd0, b} << {sel, 3'b000};
  assign remain_or = remain_r | part;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    fmt_size_nxt  = fmt_size_r;
    audio_fmt_nxt = audio_fmt_r;
    chans_nxt     = chans_r;
    rate_nxt      = rate_r;
    bits_nxt      = bits_r;
    tag_nxt       = tag_r;
    remain_nxt    = remain_r;
    res           = '0;
    res_valid     = 1'b0;
    err           = 1'b0;
    before_data   = (phase_r <= PH_CSKIP);

    case (phase_r)
      PH_RIFF, PH_WAVE, PH_FMT: begin
        tag_nxt = tag_in;
        cnt_nxt = tag_done ? 4'd0 : cnt_r + 4'd1;
        if (tag_done) begin
          if (phase_r == PH_RIFF) begin
            if (tag_in != TAG_RIFF) begin
              err            = 1'b1;
              res.error_code = ERR_NO_RIFF;
            end else begin
              phase_nxt = PH_RSIZE;
            end
          end else if (phase_r == PH_WAVE) begin
            if (tag_in != TAG_WAVE) begin
              err            = 1'b1;
              res.error_code = ERR_NO_WAVE;
            end else begin
              phase_nxt = PH_FMT;
            end
          end else begin
            if (tag_in != TAG_FMT) begin
              err            = 1'b1;
              res.error_code = ERR_NO_FMT;
            end else begin
              phase_nxt    = PH_FSIZE;
              fmt_size_nxt = '0;
            end
          end
        end
      end
      PH_RSIZE: begin
        cnt_nxt = tag_done ? 4'd0 : cnt_r + 4'd1;
        if (tag_done) begin
          phase_nxt = PH_WAVE;
        end
      end
      PH_FSIZE: begin
        fmt_size_nxt = fmt_size_r | part;
        cnt_nxt      = tag_done ? 4'd0 : cnt_r + 4'd1;
        if (tag_done) begin
          phase_nxt = PH_FBODY;
        end
      end
      PH_FBODY: begin
        if (cnt_r < 4'd2) begin
          audio_fmt_nxt = audio_fmt_r | part[15:0];
        end else if (cnt_r < 4'd4) begin
          chans_nxt = chans_r | part[15:0];
        end else if (cnt_r < 4'd8) begin
          rate_nxt = rate_r | part;
        end else if (cnt_r >= 4'd14) begin
          bits_nxt = bits_r | part[15:0];
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          cnt_nxt = 4'd0;
          if (audio_fmt_r != PCM_FORMAT) begin
            err            = 1'b1;
            res.error_code = ERR_NOT_PCM;
          end else if (fmt_size_r > PCM_BODY_BYTES) begin
            remain_nxt = fmt_size_r - PCM_BODY_BYTES;
            phase_nxt  = PH_FSKIP;
          end else begin
            phase_nxt = PH_CTAG;
          end
        end
      end
      PH_FSKIP, PH_CSKIP: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt = PH_CTAG;
          cnt_nxt   = 4'd0;
        end
      end
      PH_CTAG: begin
        tag_nxt = tag_in;
        cnt_nxt = tag_done ? 4'd0 : cnt_r + 4'd1;
        if (tag_done) begin
          phase_nxt  = PH_CSIZE;
          remain_nxt = '0;
        end
      end
      PH_CSIZE: begin
        remain_nxt = remain_or;
        cnt_nxt    = tag_done ? 4'd0 : cnt_r + 4'd1;
        if (tag_done) begin
          if (tag_r == TAG_DATA) begin
            if (remain_or == '0) begin
              err            = 1'b1;
              res.error_code = ERR_NO_DATA;
            end else if (bits_r != DEPTH_8 && bits_r != DEPTH_16) begin
              err            = 1'b1;
              res.error_code = ERR_BAD_DEPTH;
            end else begin
              res_valid       = 1'b1;
              res.kind        = KIND_FORMAT;
              res.format_code = {bits_r == DEPTH_16, chans_r != MONO_CHANNELS};
              res.rate_hz     = rate_r;
              res.data_length = remain_or;
              phase_nxt       = PH_DATA;
            end
          end else if (remain_or == '0) begin
            phase_nxt = PH_CTAG;
          end else begin
            phase_nxt = PH_CSKIP;
          end
        end
      end
      PH_DATA: begin
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = b;
        remain_nxt    = remain_dec;
        res.last_data = (remain_dec == '0) || eof;
        if (remain_dec == '0) begin
          phase_nxt = PH_DISCARD;
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      phase_nxt = PH_DISCARD;
    end

    if (eof) begin
      if (!res_valid && before_data) begin
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_NO_DATA;
      end
      phase_nxt     = PH_RIFF;
      cnt_nxt       = '0;
      fmt_size_nxt  = '0;
      audio_fmt_nxt = '0;
      chans_nxt     = '0;
      rate_nxt      = '0;
      bits_nxt      = '0;
      tag_nxt       = '0;
      remain_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      cnt_r       <= '0;
      fmt_size_r  <= '0;
      audio_fmt_r <= '0;
      chans_r     <= '0;
      rate_r      <= '0;
      bits_r      <= '0;
      tag_r       <= '0;
      remain_r    <= '0;
    end else if (byte_take) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      fmt_size_r  <= fmt_size_nxt;
      audio_fmt_r <= audio_fmt_nxt;
      chans_r     <= chans_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      tag_r       <= tag_nxt;
      remain_r    <= remain_nxt;
    end
  end

endmodule

// ===== sv/wav_header_parser_top.sv =====
// top level of the wav header parser: input queue, parser, result queue
//
//  channel  ports                         transfer when
//  input    in_push, in_full, in_item     in_push && !in_full
//  result   out_pop, out_empty, out_item  out_pop && !out_empty
//
// one byte per cycle sustained; the parser takes one queued byte per cycle unless stalled
// a result reaches the out ports through the input queue and result queue registers
// rst_n clears both queues and returns the parser to the riff tag
// a full result queue stalls the parser; the input queue then absorbs up to
// IN_DEPTH bytes before in_full rises
module wav_header_parser_top import wav_hp_pkg::*; #(
  parameter int unsigned IN_DEPTH  = IN_FIFO_DEPTH,
  parameter int unsigned OUT_DEPTH = OUT_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_item,
  output logic      out_empty
);

  localparam int unsigned IW = $bits(in_item_t);
  localparam int unsigned OW = $bits(out_item_t);

  logic [IW-1:0] q_in_data;
  logic          q_in_empty;
  logic          byte_take;
  logic          res_full;
  logic          res_push;
  out_item_t     res_item;
  logic [OW-1:0] q_out_data;

  wav_hp_fifo #(
    .WIDTH (IW),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (in_item),
    .full    (in_full),
    .pop     (byte_take),
    .rd_data (q_in_data),
    .empty   (q_in_empty)
  );

  wav_hp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (!q_in_empty),
    .byte_item  (in_item_t'(q_in_data)),
    .byte_take  (byte_take),
    .res_space  (!res_full),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  wav_hp_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (q_out_data),
    .empty   (out_empty)
  );

  assign out_item = out_item_t'(q_out_data);

endmodule
